// ===== rtl/core/at_response_line_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modem reply line parser
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_LINE_PARSER_MACROS_SVH
`define AT_RESPONSE_LINE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ATRLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atrlp: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ATRLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atrlp: next-cycle check failed");

`endif

// ===== rtl/core/atrlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlp_pkg
// Shared types, character codes and defaults of the modem reply line parser.
// ----------------------------------------------------------------------------
package atrlp_pkg;

   // Default sizing
   localparam int LINE_MAX_DEF = 64;
   localparam int DATA_MAX_DEF = 64;
   localparam int QUEUE_DEPTH  = 2;

   // Characters
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_E       = 8'h45;
   localparam logic [7:0] CH_K       = 8'h4B;
   localparam logic [7:0] CH_O       = 8'h4F;
   localparam logic [7:0] CH_R       = 8'h52;
   localparam logic [7:0] CH_V       = 8'h56;

   // Reply codes
   typedef enum logic [2:0] {
      CODE_OK   = 3'd0,
      CODE_RCV  = 3'd1,
      CODE_ERR  = 3'd2,
      CODE_ACK  = 3'd3,
      CODE_NONE = 3'd4,
      CODE_FMT  = 3'd5
   } reply_code_type;

   // Classified input byte
   typedef struct packed {
      logic [7:0] data;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_plus;
      logic       is_newline;
      logic       is_comma;
      logic       is_equal;
      logic       is_zero;
   } class_type;

   // Result item
   typedef struct packed {
      logic           event_res;
      reply_code_type reply_code;
      logic [7:0]     payload_char;
      logic [5:0]     payload_index;
      logic [15:0]    sender_id;
      logic [7:0]     declared_length;
      logic [5:0]     payload_length;
      logic [7:0]     rssi_magnitude;
      logic [7:0]     snr_value;
   } result_type;

endpackage

// ===== rtl/core/atrlp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module atrlp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = atrlp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == COUNT_MAX);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/atrlp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlp_front
// Accepts reply bytes, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module atrlp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [7:0]           rx_byte,
   input  logic                 cls_pop,
   output logic                 cls_empty,
   output atrlp_pkg::class_type cls_item
);

   atrlp_pkg::class_type cls_new;
   logic [$bits(atrlp_pkg::class_type)-1:0] cls_bits;

   // byte classification
   always_comb begin
      cls_new            = '0;
      cls_new.data       = rx_byte;
      cls_new.is_digit   = (rx_byte >= atrlp_pkg::CH_ZERO) && (rx_byte <= atrlp_pkg::CH_NINE);
      cls_new.digit      = 4'(rx_byte - atrlp_pkg::CH_ZERO);
      cls_new.is_plus    = (rx_byte == atrlp_pkg::CH_PLUS);
      cls_new.is_newline = (rx_byte == atrlp_pkg::CH_NEWLINE);
      cls_new.is_comma   = (rx_byte == atrlp_pkg::CH_COMMA);
      cls_new.is_equal   = (rx_byte == atrlp_pkg::CH_EQUAL);
      cls_new.is_zero    = (rx_byte == 8'h00);
   end

   // queue between front and back
   atrlp_fifo #(
      .WIDTH ($bits(atrlp_pkg::class_type)),
      .DEPTH (atrlp_pkg::QUEUE_DEPTH)
   ) u_cls_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls_new),
      .full      (full),
      .pop       (cls_pop),
      .pop_data  (cls_bits),
      .empty     (cls_empty)
   );

   assign cls_item = atrlp_pkg::class_type'(cls_bits);

endmodule

// ===== rtl/core/atrlp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlp_back
// Line parser: walks the reply line one classified byte per cycle while the
// result queue has room, and produces payload and summary items.
// ----------------------------------------------------------------------------
`include "at_response_line_parser_macros.svh"

module atrlp_back #(
   parameter int LINE_MAX = atrlp_pkg::LINE_MAX_DEF,
   parameter int DATA_MAX = atrlp_pkg::DATA_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cls_empty,
   input  atrlp_pkg::class_type  cls_item,
   output logic                  cls_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output atrlp_pkg::result_type rsp_item
);

   localparam int LCW   = $clog2(LINE_MAX + 1);
   localparam int DCW   = $clog2(DATA_MAX);
   localparam int CMP_W = 9;
   localparam logic [LCW-1:0]   LINE_LIMIT = LCW'(LINE_MAX);
   localparam logic [CMP_W-1:0] DATA_LIMIT = CMP_W'(DATA_MAX);
   localparam logic [CMP_W-1:0] KEEP_MAX   = CMP_W'(DATA_MAX - 1);

   typedef enum logic [11:0] {
      PH_HUNT   = 12'h001,
      PH_PREFIX = 12'h002,
      PH_OTHER  = 12'h004,
      PH_SKIPEQ = 12'h008,
      PH_ID     = 12'h010,
      PH_LEN    = 12'h020,
      PH_DATA   = 12'h040,
      PH_DASH   = 12'h080,
      PH_RSSI   = 12'h100,
      PH_SNR    = 12'h200,
      PH_DONE   = 12'h400,
      PH_BAD    = 12'h800
   } phase_type;

   typedef enum logic [5:0] {
      PM_START = 6'h01,
      PM_O     = 6'h02,
      PM_R     = 6'h04,
      PM_RC    = 6'h08,
      PM_E     = 6'h10,
      PM_ER    = 6'h20
   } prefix_type;

   phase_type                 phase_ff, phase_in;
   prefix_type                prefix_ff, prefix_in;
   atrlp_pkg::reply_code_type code_ff, code_in;
   logic [LCW-1:0]            line_count_ff, line_count_in, line_inc;
   logic [15:0]               id_ff, id_in;
   logic [7:0]                length_ff, length_in;
   logic [DCW-1:0]            data_count_ff, data_count_in;
   logic [1:0]                ack_ff, ack_in;
   logic [7:0]                rssi_ff, rssi_in;
   logic [7:0]                snr_ff, snr_in;
   logic                      fire, last, emit, no_prefix;
   logic [CMP_W-1:0]          keep_max, count_ext, count_next_ext;

   // value*10 + digit, clipped to 16 bits
   function automatic logic [15:0] sat16(input logic [15:0] acc, input logic [3:0] d);
      logic [19:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, d};
      return (v > 20'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   // value*10 + digit, clipped to 8 bits
   function automatic logic [7:0] sat8(input logic [7:0] acc, input logic [3:0] d);
      logic [11:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, d};
      return (v > 12'd255) ? 8'hFF : v[7:0];
   endfunction

   function automatic logic [7:0] ack_char(input logic [1:0] i);
      logic [7:0] c;
      unique case (i)
         2'd0:    c = atrlp_pkg::CH_A;
         2'd1:    c = atrlp_pkg::CH_C;
         default: c = atrlp_pkg::CH_K;
      endcase
      return c;
   endfunction

   assign fire      = !cls_empty && !rsp_full;
   assign cls_pop   = fire;
   assign line_inc  = line_count_ff + LCW'(1);
   assign last      = cls_item.is_newline || (line_inc >= LINE_LIMIT);
   assign count_ext = CMP_W'(data_count_ff);
   assign keep_max  = (CMP_W'(length_ff) < DATA_LIMIT) ? CMP_W'(length_ff) : KEEP_MAX;
   assign count_next_ext = CMP_W'(data_count_in);

   // parser step
   always_comb begin
      phase_in      = phase_ff;
      prefix_in     = prefix_ff;
      code_in       = code_ff;
      line_count_in = line_count_ff;
      id_in         = id_ff;
      length_in     = length_ff;
      data_count_in = data_count_ff;
      ack_in        = ack_ff;
      rssi_in       = rssi_ff;
      snr_in        = snr_ff;
      emit          = 1'b0;
      no_prefix     = 1'b0;
      rsp_push      = 1'b0;
      rsp_item      = '0;

      if (fire) begin
         if (phase_ff == PH_HUNT) begin
            // opening plus sign clears the line state
            if (cls_item.is_plus) begin
               prefix_in     = PM_START;
               code_in       = atrlp_pkg::CODE_NONE;
               line_count_in = LCW'(1);
               id_in         = '0;
               length_in     = '0;
               data_count_in = '0;
               ack_in        = '0;
               rssi_in       = '0;
               snr_in        = '0;
               phase_in      = PH_PREFIX;
            end
         end else begin
            line_count_in = line_inc;
            unique case (phase_ff)
               PH_PREFIX: begin
                  unique case (prefix_ff)
                     PM_START: begin
                        if (cls_item.data == atrlp_pkg::CH_O) prefix_in = PM_O;
                        else if (cls_item.data == atrlp_pkg::CH_R) prefix_in = PM_R;
                        else if (cls_item.data == atrlp_pkg::CH_E) prefix_in = PM_E;
                        else no_prefix = 1'b1;
                     end
                     PM_O: begin
                        if (cls_item.data == atrlp_pkg::CH_K) begin
                           code_in  = atrlp_pkg::CODE_OK;
                           phase_in = PH_OTHER;
                        end else no_prefix = 1'b1;
                     end
                     PM_R: begin
                        if (cls_item.data == atrlp_pkg::CH_C) prefix_in = PM_RC;
                        else no_prefix = 1'b1;
                     end
                     PM_RC: begin
                        if (cls_item.data == atrlp_pkg::CH_V) begin
                           code_in  = atrlp_pkg::CODE_RCV;
                           phase_in = PH_SKIPEQ;
                        end else no_prefix = 1'b1;
                     end
                     PM_E: begin
                        if (cls_item.data == atrlp_pkg::CH_R) prefix_in = PM_ER;
                        else no_prefix = 1'b1;
                     end
                     PM_ER: begin
                        if (cls_item.data == atrlp_pkg::CH_R) begin
                           code_in  = atrlp_pkg::CODE_ERR;
                           phase_in = PH_OTHER;
                        end else no_prefix = 1'b1;
                     end
                     default: no_prefix = 1'b1;
                  endcase
                  if (no_prefix) begin
                     code_in  = atrlp_pkg::CODE_NONE;
                     phase_in = PH_OTHER;
                  end
               end
               PH_SKIPEQ: begin
                  if (cls_item.is_equal) phase_in = PH_ID;
                  else if (cls_item.is_zero) phase_in = PH_BAD;
               end
               PH_ID: begin
                  if (cls_item.is_digit) id_in = sat16(id_ff, cls_item.digit);
                  else phase_in = cls_item.is_comma ? PH_LEN : PH_BAD;
               end
               PH_LEN: begin
                  if (cls_item.is_digit) length_in = sat8(length_ff, cls_item.digit);
                  else phase_in = cls_item.is_comma ? PH_DATA : PH_BAD;
               end
               PH_DATA: begin
                  if (cls_item.is_comma) phase_in = PH_DASH;
                  else if (cls_item.is_zero) phase_in = PH_BAD;
                  else if (!last && (count_ext < keep_max)) begin
                     // ACK match only along the leading payload bytes
                     if ((ack_ff != 2'd3) && (CMP_W'(ack_ff) == count_ext) &&
                         (cls_item.data == ack_char(ack_ff))) begin
                        ack_in = ack_ff + 2'd1;
                     end
                     data_count_in = data_count_ff + DCW'(1);
                     emit          = 1'b1;
                  end
               end
               PH_DASH: phase_in = PH_RSSI;
               PH_RSSI: begin
                  if (cls_item.is_digit) rssi_in = sat8(rssi_ff, cls_item.digit);
                  else phase_in = cls_item.is_comma ? PH_SNR : PH_BAD;
               end
               PH_SNR: begin
                  if (cls_item.is_digit) snr_in = sat8(snr_ff, cls_item.digit);
                  else phase_in = PH_DONE;
               end
               default: ;
            endcase

            rsp_item.sender_id       = id_in;
            rsp_item.declared_length = length_in;
            if (last) begin
               // line summary
               rsp_push                = 1'b1;
               rsp_item.event_res      = 1'b1;
               if (phase_in == PH_SNR || phase_in == PH_DONE) begin
                  rsp_item.reply_code = (ack_in == 2'd3) ? atrlp_pkg::CODE_ACK
                                                         : atrlp_pkg::CODE_RCV;
               end else if (phase_in == PH_PREFIX || phase_in == PH_OTHER) begin
                  rsp_item.reply_code = code_in;
               end else begin
                  rsp_item.reply_code = atrlp_pkg::CODE_FMT;
               end
               rsp_item.payload_length = count_next_ext[5:0];
               rsp_item.rssi_magnitude = rssi_in;
               rsp_item.snr_value      = snr_in;
               phase_in                = PH_HUNT;
            end else if (emit) begin
               // payload byte
               rsp_push               = 1'b1;
               rsp_item.event_res     = 1'b0;
               rsp_item.reply_code    = atrlp_pkg::CODE_RCV;
               rsp_item.payload_char  = cls_item.data;
               rsp_item.payload_index = count_ext[5:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         prefix_ff     <= PM_START;
         code_ff       <= atrlp_pkg::CODE_NONE;
         line_count_ff <= '0;
         id_ff         <= '0;
         length_ff     <= '0;
         data_count_ff <= '0;
         ack_ff        <= '0;
         rssi_ff       <= '0;
         snr_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         prefix_ff     <= prefix_in;
         code_ff       <= code_in;
         line_count_ff <= line_count_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         data_count_ff <= data_count_in;
         ack_ff        <= ack_in;
         rssi_ff       <= rssi_in;
         snr_ff        <= snr_in;
      end
   end

   // checks
   `ATRLP_ASSERT_NOW(a_push_needs_byte, clock, reset, rsp_push, cls_pop)
   `ATRLP_ASSERT_NOW(a_payload_is_rcv, clock, reset, rsp_push && !rsp_item.event_res, rsp_item.reply_code == atrlp_pkg::CODE_RCV)
   `ATRLP_ASSERT_NEXT(a_summary_to_hunt, clock, reset, rsp_push && rsp_item.event_res, phase_ff == PH_HUNT)
   `ATRLP_ASSERT_NOW(a_line_bound, clock, reset, 1'b1, line_count_ff <= LINE_LIMIT)

endmodule

// ===== rtl/core/at_response_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_line_parser
// Modem reply line parser, byte in, payload/summary items out.
//
// Input side: a queue port. A byte is taken at a clock edge with push high
// and full low. Result side: the oldest item sits on the rsp_ ports while
// empty is low and leaves at an edge with pop high.
// Each byte inside a line gives at most one item: a payload byte
// (rsp_event_res 0) or, for the line-ending byte, a summary (rsp_event_res 1).
// Path: a taken byte waits in the classify queue; the parser step reads it
// from there and writes its result into the result queue, whose head is on
// the rsp_ ports; a full result queue holds the parser step.
// Throughput: one byte per cycle while the result queue has room.
// A stalled receiver fills the result queue; the parser then holds and the
// input queue fills, after which full rises. No item is dropped.
// Reset empties both queues and puts the parser into plus-sign hunting.
// ----------------------------------------------------------------------------
module at_response_line_parser #(
   parameter int LINE_MAX = atrlp_pkg::LINE_MAX_DEF,
   parameter int DATA_MAX = atrlp_pkg::DATA_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_event_res,
   output logic [2:0]  rsp_reply_code,
   output logic [7:0]  rsp_payload_char,
   output logic [5:0]  rsp_payload_index,
   output logic [15:0] rsp_sender_id,
   output logic [7:0]  rsp_declared_length,
   output logic [5:0]  rsp_payload_length,
   output logic [7:0]  rsp_rssi_magnitude,
   output logic [7:0]  rsp_snr_value
);

   atrlp_pkg::class_type  cls_item;
   logic                  cls_empty, cls_pop;
   atrlp_pkg::result_type res_new, res_out;
   logic                  res_push, res_full;
   logic [$bits(atrlp_pkg::result_type)-1:0] res_bits;

   // front: accept and classify
   atrlp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rx_byte   (req_rx_byte),
      .cls_pop   (cls_pop),
      .cls_empty (cls_empty),
      .cls_item  (cls_item)
   );

   // back: line parser
   atrlp_back #(
      .LINE_MAX (LINE_MAX),
      .DATA_MAX (DATA_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_empty (cls_empty),
      .cls_item  (cls_item),
      .cls_pop   (cls_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_item  (res_new)
   );

   // result queue
   atrlp_fifo #(
      .WIDTH ($bits(atrlp_pkg::result_type)),
      .DEPTH (atrlp_pkg::QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_new),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_bits),
      .empty     (empty)
   );

   assign res_out             = atrlp_pkg::result_type'(res_bits);
   assign rsp_event_res       = res_out.event_res;
   assign rsp_reply_code      = res_out.reply_code;
   assign rsp_payload_char    = res_out.payload_char;
   assign rsp_payload_index   = res_out.payload_index;
   assign rsp_sender_id       = res_out.sender_id;
   assign rsp_declared_length = res_out.declared_length;
   assign rsp_payload_length  = res_out.payload_length;
   assign rsp_rssi_magnitude  = res_out.rssi_magnitude;
   assign rsp_snr_value       = res_out.snr_value;

endmodule

// ===== tb/sv/at_response_line_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_line_parser_tb
// Self-checking bench for the modem reply line parser. A short table of reply
// lines opens the run, then randomly built lines follow: mostly well-formed
// receive lines with random fields and payload, plus status replies, prefix
// near-misses, broken and overlong lines and line noise. A behavioral copy of
// the parser predicts the items the table does not give, and each popped item
// is compared field by field. Both sides idle at random, and the receiver
// holds off once long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module at_response_line_parser_tb;
   import atrlp_pkg::*;

   localparam int LINE_LIMIT   = LINE_MAX_DEF;
   localparam int DATA_LIMIT   = DATA_MAX_DEF;
   localparam int ACK_LEN      = 3;
   localparam int RANDOM_BYTES = 1900;
   localparam int QUIET_FROM   = 700;
   localparam int QUIET_TO     = 1000;
   localparam int IDLE_PCT     = 30;
   localparam int HOLD_CYCLES  = 200;
   // hold-off plus a generous margin for random gaps on both sides
   localparam int STALL_LIMIT  = 2000;
   // after the drain, wait for stray items the block may still emit
   localparam int DRAIN_CYCLES = 8;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // How much of a +OK / +RCV / +ERR prefix has matched so far
   localparam logic [2:0] PFX_START = 3'd0;
   localparam logic [2:0] PFX_O     = 3'd1;
   localparam logic [2:0] PFX_R     = 3'd2;
   localparam logic [2:0] PFX_RC    = 3'd3;
   localparam logic [2:0] PFX_E     = 3'd4;
   localparam logic [2:0] PFX_ER    = 3'd5;
   localparam logic [2:0] PFX_MISS  = 3'd6;

   typedef enum logic [3:0] {
      ST_HUNT, ST_PREFIX, ST_OTHER, ST_SKIP_EQ, ST_ID, ST_LEN, ST_DATA,
      ST_SIGN, ST_RSSI, ST_SNR, ST_DONE, ST_BAD
   } line_state_type;

   typedef struct {
      logic [7:0] rx;
      bit         typed;
      result_type want;
   } plan_row_type;

   // DUT ports
   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_rx_byte;
   logic        empty;
   logic        pop;
   logic        rsp_event_res;
   logic [2:0]  rsp_reply_code;
   logic [7:0]  rsp_payload_char;
   logic [5:0]  rsp_payload_index;
   logic [15:0] rsp_sender_id;
   logic [7:0]  rsp_declared_length;
   logic [5:0]  rsp_payload_length;
   logic [7:0]  rsp_rssi_magnitude;
   logic [7:0]  rsp_snr_value;

   // Typed expectation riding along with the byte being offered
   bit          byte_typed;
   result_type  byte_want;

   // Parser model state
   line_state_type lp_state    = ST_HUNT;
   logic [2:0]     prefix_seen = PFX_START;
   int unsigned    line_bytes  = 0;
   int unsigned    id_val      = 0;
   int unsigned    len_val     = 0;
   int unsigned    kept_count  = 0;
   int unsigned    ack_seen    = 0;
   int unsigned    rssi_val    = 0;
   int unsigned    snr_val     = 0;
   reply_code_type line_kind   = CODE_NONE;

   // Bench bookkeeping
   result_type     items_due[$];
   plan_row_type   plan[$];
   logic [7:0]     line_q[$];
   int             err_count     = 0;
   int             bytes_sent    = 0;
   int             payload_items = 0;
   int             line_items    = 0;
   int             code_hits [0:5];
   int             stall_cycles  = 0;
   int             send_idle_pct = IDLE_PCT;
   int             recv_idle_pct = IDLE_PCT;
   bit             hold_rsp      = 1'b0;

   at_response_line_parser u_top (.*);

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic bit is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic int unsigned add_digit(int unsigned acc, logic [7:0] b,
                                             int unsigned cap);
      int unsigned v;
      v = acc * 10 + (b - CH_ZERO);
      return (v > cap) ? cap : v;
   endfunction

   // Advance the model by one byte; returns 1 when the byte yields an item
   function automatic bit parse_byte(input logic [7:0] b, output result_type r);
      bit          last;
      bit          emit;
      bit          matched;
      logic [2:0]  nxt;
      int unsigned keep_max;
      int unsigned pos;
      logic [7:0]  ack_char;
      r       = '0;
      emit    = 1'b0;
      matched = 1'b0;
      nxt     = PFX_MISS;
      pos     = 0;

      // a plus sign opens a line and clears everything per line
      if (lp_state == ST_HUNT) begin
         if (b == CH_PLUS) begin
            prefix_seen = PFX_START;
            id_val      = 0;
            len_val     = 0;
            kept_count  = 0;
            ack_seen    = 0;
            rssi_val    = 0;
            snr_val     = 0;
            line_kind   = CODE_NONE;
            line_bytes  = 1;
            lp_state    = ST_PREFIX;
         end
         return 1'b0;
      end

      line_bytes++;
      last = (b == CH_NEWLINE) || (line_bytes >= LINE_LIMIT);

      case (lp_state)
         ST_PREFIX: begin
            case (prefix_seen)
               PFX_START: begin
                  if (b == CH_O) nxt = PFX_O;
                  else if (b == CH_R) nxt = PFX_R;
                  else if (b == CH_E) nxt = PFX_E;
               end
               PFX_O: if (b == CH_K) begin
                  line_kind = CODE_OK;
                  lp_state  = ST_OTHER;
                  matched   = 1'b1;
               end
               PFX_R: if (b == CH_C) nxt = PFX_RC;
               PFX_RC: if (b == CH_V) begin
                  line_kind = CODE_RCV;
                  lp_state  = ST_SKIP_EQ;
                  matched   = 1'b1;
               end
               PFX_E: if (b == CH_R) nxt = PFX_ER;
               PFX_ER: if (b == CH_R) begin
                  line_kind = CODE_ERR;
                  lp_state  = ST_OTHER;
                  matched   = 1'b1;
               end
               default: ;
            endcase
            if (!matched) begin
               if (nxt == PFX_MISS) begin
                  line_kind = CODE_NONE;
                  lp_state  = ST_OTHER;
               end else begin
                  prefix_seen = nxt;
               end
            end
         end
         ST_SKIP_EQ: begin
            if (b == CH_EQUAL) lp_state = ST_ID;
            else if (b == CH_NUL) lp_state = ST_BAD;
         end
         ST_ID: begin
            if (is_digit(b)) id_val = add_digit(id_val, b, 65535);
            else if (b == CH_COMMA) lp_state = ST_LEN;
            else lp_state = ST_BAD;
         end
         ST_LEN: begin
            if (is_digit(b)) len_val = add_digit(len_val, b, 255);
            else if (b == CH_COMMA) lp_state = ST_DATA;
            else lp_state = ST_BAD;
         end
         ST_DATA: begin
            keep_max = (len_val < DATA_LIMIT) ? len_val : DATA_LIMIT - 1;
            if (b == CH_COMMA) lp_state = ST_SIGN;
            else if (b == CH_NUL) lp_state = ST_BAD;
            else if (!last && kept_count < keep_max) begin
               // ACK only counts from the very first payload byte on
               ack_char = (ack_seen == 0) ? CH_A : (ack_seen == 1) ? CH_C : CH_K;
               if (ack_seen < ACK_LEN && ack_seen == kept_count && b == ack_char)
                  ack_seen++;
               pos = kept_count;
               kept_count++;
               emit = 1'b1;
            end
         end
         ST_SIGN: lp_state = ST_RSSI;
         ST_RSSI: begin
            if (is_digit(b)) rssi_val = add_digit(rssi_val, b, 255);
            else if (b == CH_COMMA) lp_state = ST_SNR;
            else lp_state = ST_BAD;
         end
         ST_SNR: begin
            if (is_digit(b)) snr_val = add_digit(snr_val, b, 255);
            else lp_state = ST_DONE;
         end
         default: ;
      endcase

      r.sender_id       = id_val[15:0];
      r.declared_length = len_val[7:0];

      // line end: summary only, never a payload byte
      if (last) begin
         r.event_res = 1'b1;
         if (lp_state == ST_SNR || lp_state == ST_DONE) begin
            if (ack_seen == ACK_LEN) r.reply_code = CODE_ACK;
            else r.reply_code = CODE_RCV;
         end else if (lp_state == ST_PREFIX || lp_state == ST_OTHER) begin
            r.reply_code = line_kind;
         end else begin
            r.reply_code = CODE_FMT;
         end
         r.payload_length = kept_count[5:0];
         r.rssi_magnitude = rssi_val[7:0];
         r.snr_value      = snr_val[7:0];
         lp_state         = ST_HUNT;
         return 1'b1;
      end
      if (emit) begin
         r.event_res     = 1'b0;
         r.reply_code    = CODE_RCV;
         r.payload_char  = b;
         r.payload_index = pos[5:0];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Directed table helpers
   // ------------------------------------------------------------------------
   function automatic result_type line_summary(reply_code_type code,
                                               logic [7:0] declared,
                                               logic [5:0] kept);
      result_type r;
      r                 = '0;
      r.event_res       = 1'b1;
      r.reply_code      = code;
      r.declared_length = declared;
      r.payload_length  = kept;
      return r;
   endfunction

   function automatic void plan_byte(logic [7:0] b, bit typed, result_type want);
      plan_row_type row;
      row.rx    = b;
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endfunction

   function automatic void plan_text(string s);
      for (int i = 0; i < s.len(); i++) plan_byte(s[i], 1'b0, '0);
   endfunction

   // ------------------------------------------------------------------------
   // Random line builder
   // ------------------------------------------------------------------------
   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endfunction

   function automatic void put_num(int unsigned v);
      put_text($sformatf("%0d", v));
   endfunction

   // Any byte that does not end the line
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
      return b;
   endfunction

   // Any byte a payload may legally hold
   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == CH_COMMA || b == CH_NEWLINE || b == CH_NUL);
      return b;
   endfunction

   // Decimal field: empty, in range, with a leading zero, near or just past the cap, or well past it
   function automatic void put_field(int unsigned cap);
      case ($urandom_range(9))
         0: ;
         1: put_num($urandom);
         2: put_num(cap + $urandom_range(1, 9));
         3: put_num(cap - $urandom_range(0, 1));
         4: begin
            put_text("0");
            put_num($urandom_range(99));
         end
         default: put_num($urandom_range(cap));
      endcase
   endfunction

   function automatic void build_line();
      int unsigned pick;
      int unsigned plen;
      int unsigned count;
      int unsigned pos;
      bit          want_ack;
      line_q.delete();

      // line noise ahead of the plus sign
      if ($urandom_range(99) < 30)
         repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(255)));

      pick = $urandom_range(99);
      if (pick < 65) begin
         // receive line, mostly well formed
         put_text("+RCV");
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) line_q.push_back(payload_byte());
         put_text("=");
         put_field(65535);
         put_text(",");
         plen = ($urandom_range(3) == 0) ? $urandom_range(24) : $urandom_range(8);
         case ($urandom_range(9))
            0: count = plen + $urandom_range(1, 5);
            1: count = $urandom_range(plen);
            2: count = $urandom_range(256, 999);
            default: count = plen;
         endcase
         put_num(count);
         put_text(",");
         want_ack = ($urandom_range(3) == 0);
         for (int i = 0; i < plen; i++) begin
            if (want_ack && i < ACK_LEN)
               line_q.push_back((i == 0) ? CH_A : (i == 1) ? CH_C : CH_K);
            else
               line_q.push_back(payload_byte());
         end
         put_text(",");
         line_q.push_back(($urandom_range(9) < 8) ? CH_MINUS : 8'($urandom_range(255)));
         put_field(255);
         put_text(",");
         put_field(255);
         // broken copy: one byte replaced, or the line cut short
         if ($urandom_range(4) == 0) begin
            pos = $urandom_range(1, line_q.size() - 1);
            if ($urandom_range(1) == 0) begin
               line_q[pos] = 8'($urandom_range(255));
            end else begin
               while (line_q.size() > pos) void'(line_q.pop_back());
            end
         end
      end else if (pick < 95) begin
         // status replies and prefix near-misses
         line_q.push_back(CH_PLUS);
         case ($urandom_range(9))
            0, 1: put_text("OK");
            2, 3: put_text("ERR");
            4: put_text("RCV");
            5: put_text("O");
            6: put_text("ER");
            7: put_text("RC");
            8: put_text("E");
            default: ;
         endcase
         repeat ($urandom_range(0, 6)) line_q.push_back(body_byte());
      end else begin
         // runs into the line length cap
         line_q.push_back(CH_PLUS);
         repeat (LINE_LIMIT + 6) line_q.push_back(body_byte());
      end

      case ($urandom_range(9))
         8: begin
            repeat ($urandom_range(1, 4)) line_q.push_back(body_byte());
            line_q.push_back(CH_NEWLINE);
         end
         9: ;
         default: line_q.push_back(CH_NEWLINE);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Sender: changes at the falling edge, holds until the byte is taken
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input bit typed, input result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      byte_typed  <= typed;
      byte_want   <= want;
      do @(posedge clock); while (full);
      @(negedge clock);
      bytes_sent++;
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random pops, one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : receiver
      pop <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare popped items, then predict from the byte taken
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin : item_check
      result_type got;
      result_type want;
      result_type pred;
      bit         made;
      if (!reset) begin
         if (pop && !empty) begin
            got.event_res       = rsp_event_res;
            got.reply_code      = reply_code_type'(rsp_reply_code);
            got.payload_char    = rsp_payload_char;
            got.payload_index   = rsp_payload_index;
            got.sender_id       = rsp_sender_id;
            got.declared_length = rsp_declared_length;
            got.payload_length  = rsp_payload_length;
            got.rssi_magnitude  = rsp_rssi_magnitude;
            got.snr_value       = rsp_snr_value;
            if (items_due.size() == 0) begin
               $display("%0t: unexpected item, expected none, got event %0d code %0d",
                        $time, got.event_res, got.reply_code);
               err_count++;
            end else begin
               want = items_due.pop_front();
               check_field("event_res", want.event_res, got.event_res);
               check_field("reply_code", want.reply_code, got.reply_code);
               check_field("payload_char", want.payload_char, got.payload_char);
               check_field("payload_index", want.payload_index, got.payload_index);
               check_field("sender_id", want.sender_id, got.sender_id);
               check_field("declared_length", want.declared_length, got.declared_length);
               check_field("payload_length", want.payload_length, got.payload_length);
               check_field("rssi_magnitude", want.rssi_magnitude, got.rssi_magnitude);
               check_field("snr_value", want.snr_value, got.snr_value);
               if (want.event_res) begin
                  line_items++;
                  code_hits[want.reply_code]++;
               end else begin
                  payload_items++;
               end
            end
         end
         if (push && !full) begin
            made = parse_byte(req_rx_byte, pred);
            if (byte_typed) items_due.push_back(byte_want);
            else if (made) items_due.push_back(pred);
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles = 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles++;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int directed_bytes;
      reset       <= 1'b1;
      push        <= 1'b0;
      req_rx_byte <= '0;
      byte_typed  <= 1'b0;
      byte_want   <= '0;
      foreach (code_hits[c]) code_hits[c] = 0;

      // Directed lines: noise at both byte extremes, each reply class but a plain receive
      plan_byte(CH_NUL, 1'b0, '0);
      plan_byte(8'hFF, 1'b0, '0);
      plan_text("+OK");
      plan_byte(CH_NEWLINE, 1'b1, line_summary(CODE_OK, 8'd0, 6'd0));
      plan_text("+ERR");
      plan_byte(CH_NEWLINE, 1'b1, line_summary(CODE_ERR, 8'd0, 6'd0));
      plan_text("+Z");
      plan_byte(CH_NEWLINE, 1'b1, line_summary(CODE_NONE, 8'd0, 6'd0));
      plan_text("+RCV");
      plan_byte(CH_NEWLINE, 1'b1, line_summary(CODE_FMT, 8'd0, 6'd0));
      plan_text("+RCV=,3,ACK,-,");
      plan_byte(CH_NEWLINE, 1'b1, line_summary(CODE_ACK, 8'd3, 6'd3));
      directed_bytes = plan.size();

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) send_byte(plan[k].rx, plan[k].typed, plan[k].want);

      // Random lines; the receiver backs off first so the block fills up
      hold_rsp = 1'b1;
      while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
         if (bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = IDLE_PCT;
            recv_idle_pct = IDLE_PCT;
         end
         build_line();
         foreach (line_q[k]) send_byte(line_q[k], 1'b0, '0);
      end
      push <= 1'b0;

      // Drain, then allow for anything the block still emits
      while (items_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d reply bytes; checked %0d payload items and %0d line summaries.",
               bytes_sent, payload_items, line_items);
      $display("Summaries by class: ok %0d, receive %0d, error %0d, ack %0d, %s %0d, %s %0d.",
               code_hits[CODE_OK], code_hits[CODE_RCV], code_hits[CODE_ERR],
               code_hits[CODE_ACK], "no prefix", code_hits[CODE_NONE],
               "bad format", code_hits[CODE_FMT]);
      if (err_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
